[design/mgp_pkg.sv]
package mgp_pkg;

	localparam int unsigned BLOCKS_PER_SIDE = 12;
	localparam logic [3:0]  LAST_BLOCK      = 4'(BLOCKS_PER_SIDE - 1);
	localparam logic [7:0]  WIDTH_RESET     = 8'd10;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [7:0]  SHADE_WHITE     = 8'hFF;
	localparam logic [7:0]  SHADE_BLACK     = 8'h00;
	localparam int unsigned CFG_INDEX_W     = 4;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_WIDTH = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_MARKER_ID   = CFG_INDEX_W'(1);

	// status of the checksum unit as seen by the top level
	typedef struct packed {
		logic        busy;
		logic [15:0] value;
	} crc_status_t;

	// one byte of reflected crc-16 (arc)
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[design/mgp_crc.sv]
module mgp_crc import mgp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] id,
	output crc_status_t status
);

	logic [63:0] id_q;
	logic [15:0] crc_q;
	logic [2:0]  cnt_q;
	logic        busy_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
			crc_q  <= 16'h0000;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 3'd0;
			crc_q  <= 16'h0000;
		end else if (busy_q) begin
			crc_q <= crc_byte(crc_q, id_q[7:0]);
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	// byte shifter, least significant byte first
	always_ff @(posedge clk) begin
		if (start) begin
			id_q <= id;
		end else if (busy_q) begin
			id_q <= {8'h00, id_q[63:8]};
		end
	end

	assign status.busy  = busy_q;
	assign status.value = crc_q;

endmodule

[design/marker_grid_pixel_generator_unit.sv]
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    restart
// result    out        out_valid / out_ready  pixel_value, end_of_line, end_of_frame
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one pixel per clock: a request is taken whenever the result register is empty or
// being drained, and its pixel appears in the result register the next cycle
// after a marker_id write the byte-serial checksum unit runs over the eight id bytes; input
// and config requests wait during that time
// reset: block_width 10, marker_id 0, position zero, latched checksum zero
// a stalled result holds the input: in_ready stays low until the result is taken
module marker_grid_pixel_generator_unit import mgp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// input requests
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   restart,
	// results
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             pixel_value,
	output logic                   end_of_line,
	output logic                   end_of_frame,
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]            cfg_data
);

	// configuration registers
	logic [7:0]  block_width_q;
	logic [63:0] marker_id_q;

	// raster position and latched checksum
	logic [7:0]  pix_col_q;
	logic [7:0]  pix_row_q;
	logic [3:0]  blk_col_q;
	logic [3:0]  blk_row_q;
	logic [15:0] checksum_q;

	// result register
	logic        out_valid_q;
	logic [7:0]  pixel_q;
	logic        eol_q;
	logic        eof_q;

	crc_status_t crc_status;
	logic        cfg_fire;
	logic        in_fire;
	logic        crc_start;

	assign cfg_ready = !crc_status.busy;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign crc_start = cfg_fire && (cfg_index == CFG_MARKER_ID);

	mgp_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (crc_start),
		.id     (cfg_data),
		.status (crc_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_width_q <= WIDTH_RESET;
			marker_id_q   <= 64'h0;
		end else if (cfg_fire) begin
			case (cfg_index)
				CFG_BLOCK_WIDTH: block_width_q <= cfg_data[7:0];
				CFG_MARKER_ID:   marker_id_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// take a request while the checksum unit is idle and the result slot is empty or frees up this edge
	assign in_ready = !crc_status.busy && (!out_valid_q || out_ready);
	assign in_fire  = in_valid && in_ready;

	// a zero width counts as one, so the wrap limit is simply width minus one
	logic [7:0]  wrap_lim;
	assign wrap_lim = (block_width_q == 8'd0) ? 8'd0 : block_width_q - 8'd1;

	// position after an optional restart
	logic [7:0]  cur_pc, cur_pr;
	logic [3:0]  cur_bc, cur_br;
	logic [15:0] cur_chk;
	assign cur_pc  = restart ? 8'd0 : pix_col_q;
	assign cur_pr  = restart ? 8'd0 : pix_row_q;
	assign cur_bc  = restart ? 4'd0 : blk_col_q;
	assign cur_br  = restart ? 4'd0 : blk_row_q;
	assign cur_chk = restart ? crc_status.value : checksum_q;

	logic col_end, row_end, eol, eof;
	assign col_end = cur_pc >= wrap_lim;
	assign row_end = cur_pr >= wrap_lim;
	assign eol     = col_end && (cur_bc >= LAST_BLOCK);
	assign eof     = eol && row_end && (cur_br >= LAST_BLOCK);

	// block shade
	logic [7:0] shade;
	logic [3:0] dr, dc;
	logic [7:0] row_byte;
	always_comb begin
		dr = cur_br - 4'd2;
		dc = cur_bc - 4'd2;
		case (dr)
			4'd6:    row_byte = cur_chk[7:0];
			4'd7:    row_byte = cur_chk[15:8];
			default: row_byte = marker_id_q[{dr[2:0], 3'b000} +: 8];
		endcase
		if (cur_br == 4'd0 || cur_bc == 4'd0 || cur_br >= LAST_BLOCK
				|| cur_bc >= LAST_BLOCK) begin
			shade = SHADE_BLACK;  // outer ring
		end else if (cur_br == 4'd1 || cur_bc == 4'd1 || cur_br == LAST_BLOCK - 4'd1
				|| cur_bc == LAST_BLOCK - 4'd1) begin
			// inner ring: white only at three corners
			if ((cur_br == 4'd1 && cur_bc == 4'd1)
					|| (cur_br == 4'd1 && cur_bc == LAST_BLOCK - 4'd1)
					|| (cur_br == LAST_BLOCK - 4'd1 && cur_bc == 4'd1)) begin
				shade = SHADE_WHITE;
			end else begin
				shade = SHADE_BLACK;
			end
		end else begin
			// data field, bit j of the row byte in column j
			shade = row_byte[dc[2:0]] ? SHADE_WHITE : SHADE_BLACK;
		end
	end

	// position advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_col_q  <= 8'd0;
			pix_row_q  <= 8'd0;
			blk_col_q  <= 4'd0;
			blk_row_q  <= 4'd0;
			checksum_q <= 16'h0000;
		end else if (in_fire) begin
			checksum_q <= cur_chk;
			pix_col_q  <= cur_pc;
			pix_row_q  <= cur_pr;
			blk_col_q  <= cur_bc;
			blk_row_q  <= cur_br;
			if (!col_end) begin
				pix_col_q <= cur_pc + 8'd1;
			end else begin
				pix_col_q <= 8'd0;
				if (cur_bc < LAST_BLOCK) begin
					blk_col_q <= cur_bc + 4'd1;
				end else begin
					blk_col_q <= 4'd0;
					if (!row_end) begin
						pix_row_q <= cur_pr + 8'd1;
					end else begin
						pix_row_q <= 8'd0;
						blk_row_q <= (cur_br < LAST_BLOCK) ? cur_br + 4'd1 : 4'd0;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pixel_q <= shade;
			eol_q   <= eol;
			eof_q   <= eof;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_value  = pixel_q;
	assign end_of_line  = eol_q;
	assign end_of_frame = eof_q;

endmodule
